FILE: src/dqco_pkg.sv
// dqco_pkg: shared types, codes and constants of the dq current observer
// no dependencies; used by dqco_mac, dqco_seq and dq_current_observer_unit

package dqco_pkg;

  // default widths
  localparam int SAMPLE_WIDTH   = 16;
  localparam int GAIN_FRAC_BITS = 14;
  localparam int GAIN_W         = 16;
  localparam int SUM_W          = 32;
  localparam int CFG_ADDR_W     = 4;

  // 32-bit saturation bounds of the accumulating sums
  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN_D  = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN_D = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN_Q  = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN_Q = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_POLE_GAIN_D  = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_POLE_GAIN_Q  = 4'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_INPUT_GAIN_D = 4'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_INPUT_GAIN_Q = 4'd7;

  // register reset values
  localparam logic [GAIN_W-1:0] RST_PROP_GAIN_D  = 16'd501;
  localparam logic [GAIN_W-1:0] RST_INTEG_GAIN_D = 16'd503;
  localparam logic [GAIN_W-1:0] RST_PROP_GAIN_Q  = 16'd537;
  localparam logic [GAIN_W-1:0] RST_INTEG_GAIN_Q = 16'd503;
  localparam logic [GAIN_W-1:0] RST_POLE_GAIN_D  = 16'd8178;
  localparam logic [GAIN_W-1:0] RST_POLE_GAIN_Q  = 16'd8460;
  localparam logic [GAIN_W-1:0] RST_INPUT_GAIN_D = 16'd31561;
  localparam logic [GAIN_W-1:0] RST_INPUT_GAIN_Q = 16'd30479;

  // gain select
  localparam logic [1:0] GSEL_KP = 2'd0;
  localparam logic [1:0] GSEL_KI = 2'd1;
  localparam logic [1:0] GSEL_A  = 2'd2;
  localparam logic [1:0] GSEL_B  = 2'd3;

  // multiplier operand select
  localparam logic [1:0] MSEL_ERR = 2'd0;
  localparam logic [1:0] MSEL_SUM = 2'd1;
  localparam logic [1:0] MSEL_EST = 2'd2;
  localparam logic [1:0] MSEL_TOT = 2'd3;

  // adder first operand select
  localparam logic [1:0] ASEL_ZERO = 2'd0;
  localparam logic [1:0] ASEL_MEAS = 2'd1;
  localparam logic [1:0] ASEL_SUM  = 2'd2;
  localparam logic [1:0] ASEL_FB   = 2'd3;

  // adder second operand select
  localparam logic [1:0] BSEL_EST  = 2'd0;
  localparam logic [1:0] BSEL_ERR  = 2'd1;
  localparam logic [1:0] BSEL_VOLT = 2'd2;
  localparam logic [1:0] BSEL_FB   = 2'd3;

  // result destination
  localparam logic [2:0] DST_NONE = 3'd0;
  localparam logic [2:0] DST_ERR  = 3'd1;
  localparam logic [2:0] DST_SUM  = 3'd2;
  localparam logic [2:0] DST_FB   = 3'd3;
  localparam logic [2:0] DST_TOT  = 3'd4;
  localparam logic [2:0] DST_EST  = 3'd5;
  localparam logic [2:0] DST_EMF  = 3'd6;

  typedef struct packed {
    logic mul_en;    // load product register
    logic add_en;    // load accumulator register
    logic use_acc;   // first adder input is the accumulator
    logic use_prod;  // second adder input is the scaled product
    logic sub;       // subtract second input
    logic sat;       // saturate result to 32 bits
  } mac_ctrl_t;

  typedef struct packed {
    mac_ctrl_t  mac;
    logic       axis;      // 0 = d, 1 = q
    logic [1:0] gain_sel;
    logic [1:0] mul_sel;
    logic [1:0] a_sel;
    logic [1:0] b_sel;
    logic [2:0] dst;
  } seq_ctrl_t;

endpackage

FILE: src/dqco_mac.sv
// dqco_mac: shared multiplier and saturating adder of the observer
// registered gain product, wide accumulator; uses dqco_pkg

module dqco_mac #(
  parameter int OPND_W         = dqco_pkg::SUM_W + 1,
  parameter int GAIN_FRAC_BITS = dqco_pkg::GAIN_FRAC_BITS
) (
  input  logic                                clk,
  input  dqco_pkg::mac_ctrl_t                 ctrl,
  input  logic        [dqco_pkg::GAIN_W-1:0]  gain,
  input  logic signed [OPND_W-1:0]            mul_opnd,
  input  logic signed [OPND_W-1:0]            opnd_a,
  input  logic signed [OPND_W-1:0]            opnd_b,
  output logic signed [OPND_W-1:0]            res
);

  localparam int PROD_W = dqco_pkg::GAIN_W + 1 + OPND_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam logic signed [ACC_W-1:0] S_MAX = ACC_W'(dqco_pkg::SUM_MAX);
  localparam logic signed [ACC_W-1:0] S_MIN = ACC_W'(dqco_pkg::SUM_MIN);

  logic signed [dqco_pkg::GAIN_W:0] gain_s;
  logic signed [PROD_W-1:0]         prod_full;
  logic signed [PROD_W-1:0]         prod;
  logic signed [PROD_W-1:0]         prod_sh;
  logic signed [ACC_W-1:0]          acc;
  logic signed [ACC_W-1:0]          x_in;
  logic signed [ACC_W-1:0]          y_in;
  logic signed [ACC_W-1:0]          sum;

  // unsigned gain times signed operand
  assign gain_s    = {1'b0, gain};
  assign prod_full = gain_s * mul_opnd;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= prod_full;
    end
    if (ctrl.add_en) begin
      acc <= sum;
    end
  end

  // arithmetic shift rounds toward minus infinity
  assign prod_sh = prod >>> GAIN_FRAC_BITS;

  always_comb begin
    x_in = ctrl.use_acc  ? acc : ACC_W'(opnd_a);
    y_in = ctrl.use_prod ? ACC_W'(prod_sh) : ACC_W'(opnd_b);
    sum  = ctrl.sub ? (x_in - y_in) : (x_in + y_in);
    if (ctrl.sat && (sum > S_MAX)) begin
      res = OPND_W'(S_MAX);
    end else if (ctrl.sat && (sum < S_MIN)) begin
      res = OPND_W'(S_MIN);
    end else begin
      res = sum[OPND_W-1:0];
    end
  end

endmodule

FILE: src/dqco_seq.sv
// dqco_seq: step sequencer of the observer, eight steps per axis
// drives dqco_mac and the operand selection; uses dqco_pkg

module dqco_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 clear,
  input  logic                 out_free,
  output logic                 busy,
  output logic                 load_out,
  output dqco_pkg::seq_ctrl_t  ctrl
);

  localparam int STEP_W = 4;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [STEP_W-1:0] STEP_LAST = 4'd15;

  // step within one axis
  localparam logic [2:0] K_ERR    = 3'd0;
  localparam logic [2:0] K_SUM    = 3'd1;
  localparam logic [2:0] K_KP     = 3'd2;
  localparam logic [2:0] K_FB     = 3'd3;
  localparam logic [2:0] K_TOT    = 3'd4;
  localparam logic [2:0] K_POLE   = 3'd5;
  localparam logic [2:0] K_EST    = 3'd6;
  localparam logic [2:0] K_EMF    = 3'd7;

  logic [1:0]        state;
  logic [STEP_W-1:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          step <= '0;
          if (start) begin
            state <= ST_RUN;
          end else if (clear) begin
            state <= ST_DONE;
          end
        end
        ST_RUN: begin
          step <= step + 1'b1;
          if (step == STEP_LAST) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy     = (state != ST_IDLE);
  assign load_out = (state == ST_DONE) && out_free;

  always_comb begin
    ctrl      = '0;
    ctrl.axis = step[STEP_W-1];
    if (state == ST_RUN) begin
      case (step[2:0])
        K_ERR: begin
          // err = meas - est
          ctrl.mac.add_en = 1'b1;
          ctrl.mac.sub    = 1'b1;
          ctrl.a_sel      = dqco_pkg::ASEL_MEAS;
          ctrl.b_sel      = dqco_pkg::BSEL_EST;
          ctrl.dst        = dqco_pkg::DST_ERR;
        end
        K_SUM: begin
          // kp*err; sum = sat(sum + err)
          ctrl.mac.mul_en = 1'b1;
          ctrl.gain_sel   = dqco_pkg::GSEL_KP;
          ctrl.mul_sel    = dqco_pkg::MSEL_ERR;
          ctrl.mac.add_en = 1'b1;
          ctrl.mac.sat    = 1'b1;
          ctrl.a_sel      = dqco_pkg::ASEL_SUM;
          ctrl.b_sel      = dqco_pkg::BSEL_ERR;
          ctrl.dst        = dqco_pkg::DST_SUM;
        end
        K_KP: begin
          // ki*sum; acc = kp term
          ctrl.mac.mul_en   = 1'b1;
          ctrl.gain_sel     = dqco_pkg::GSEL_KI;
          ctrl.mul_sel      = dqco_pkg::MSEL_SUM;
          ctrl.mac.add_en   = 1'b1;
          ctrl.mac.use_prod = 1'b1;
          ctrl.a_sel        = dqco_pkg::ASEL_ZERO;
        end
        K_FB: begin
          // fb = sat(acc + ki term)
          ctrl.mac.add_en   = 1'b1;
          ctrl.mac.use_acc  = 1'b1;
          ctrl.mac.use_prod = 1'b1;
          ctrl.mac.sat      = 1'b1;
          ctrl.dst          = dqco_pkg::DST_FB;
        end
        K_TOT: begin
          // a*est (previous estimate); tot = sat(fb + v)
          ctrl.mac.mul_en = 1'b1;
          ctrl.gain_sel   = dqco_pkg::GSEL_A;
          ctrl.mul_sel    = dqco_pkg::MSEL_EST;
          ctrl.mac.add_en = 1'b1;
          ctrl.mac.sat    = 1'b1;
          ctrl.a_sel      = dqco_pkg::ASEL_FB;
          ctrl.b_sel      = dqco_pkg::BSEL_VOLT;
          ctrl.dst        = dqco_pkg::DST_TOT;
        end
        K_POLE: begin
          // b*tot; acc = pole term
          ctrl.mac.mul_en   = 1'b1;
          ctrl.gain_sel     = dqco_pkg::GSEL_B;
          ctrl.mul_sel      = dqco_pkg::MSEL_TOT;
          ctrl.mac.add_en   = 1'b1;
          ctrl.mac.use_prod = 1'b1;
          ctrl.a_sel        = dqco_pkg::ASEL_ZERO;
        end
        K_EST: begin
          // est = sat(acc + input term)
          ctrl.mac.add_en   = 1'b1;
          ctrl.mac.use_acc  = 1'b1;
          ctrl.mac.use_prod = 1'b1;
          ctrl.mac.sat      = 1'b1;
          ctrl.dst          = dqco_pkg::DST_EST;
        end
        K_EMF: begin
          // emf = sat(-fb)
          ctrl.mac.add_en = 1'b1;
          ctrl.mac.sub    = 1'b1;
          ctrl.mac.sat    = 1'b1;
          ctrl.a_sel      = dqco_pkg::ASEL_ZERO;
          ctrl.b_sel      = dqco_pkg::BSEL_FB;
          ctrl.dst        = dqco_pkg::DST_EMF;
        end
        default: begin
          ctrl.dst = dqco_pkg::DST_NONE;
        end
      endcase
    end
  end

endmodule

FILE: src/dq_current_observer_unit.sv
// dq_current_observer_unit: two-axis pi current observer with back-emf estimate
// top level; instantiates dqco_seq and dqco_mac, uses dqco_pkg
//
// channel   direction  signals                          beat content
// s_*       in         s_tvalid s_tready s_tdata s_tuser one sample, tuser = mode
// m_*       out        m_tvalid m_tready m_tdata         estimates and back-emf
// cfg_*     in         cfg_we cfg_addr cfg_wdata         gain register write
//
// a sample gives its result after 16 steps of the shared multiplier/adder
// (8 per axis, a product, a sum or both per step) and the load of the output
// register once the output is free
// a clear beat (mode 1) runs no steps and gives an all-zero result
// s_tready is low from the beat until the result is loaded, so no new beat is
// taken before the last beat's result is loaded; the output register holds a
// finished result, so a new beat can be taken while m_tready is low, and the
// next result waits in the done state until the output is free
// rst is synchronous; it clears the state, the gains to their defaults and
// the output valid

module dq_current_observer_unit #(
  parameter int SAMPLE_WIDTH   = dqco_pkg::SAMPLE_WIDTH,
  parameter int GAIN_FRAC_BITS = dqco_pkg::GAIN_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // sample input
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // from bit 0: meas_current_d, meas_current_q, cmd_voltage_d, cmd_voltage_q
  input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  // bit 0: mode
  input  logic                              s_tuser,
  // result output
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // from bit 0: est_current_d, est_current_q, emf_est_d, emf_est_q
  output logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
  // register writes
  input  logic                              cfg_we,
  input  logic [dqco_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [dqco_pkg::GAIN_W-1:0]       cfg_wdata
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int DATA_W = ((4*SAMPLE_WIDTH+7)/8)*8;
  localparam int SUM_W  = dqco_pkg::SUM_W;
  localparam int GAIN_W = dqco_pkg::GAIN_W;
  // operand width: 32-bit sums, or the error of two samples if wider
  localparam int OPND_W = (SW + 1 > SUM_W) ? SW + 1 : SUM_W;

  localparam longint SMP_MAX_L = (longint'(1) <<< (SW - 1)) - 1;
  localparam logic signed [OPND_W-1:0] SMP_MAX = OPND_W'(SMP_MAX_L);
  localparam logic signed [OPND_W-1:0] SMP_MIN = OPND_W'(-SMP_MAX_L - 1);

  // gains
  logic [GAIN_W-1:0] kp_d, ki_d, kp_q, ki_q, a_d, a_q, b_d, b_q;

  // sample registers
  logic signed [SW-1:0] meas_d, meas_q, volt_d, volt_q;

  // observer state
  logic signed [SW-1:0]    est_d, est_q;
  logic signed [SUM_W-1:0] sum_d, sum_q;

  // per-axis working registers
  logic signed [OPND_W-1:0] err;
  logic signed [SUM_W-1:0]  fb;
  logic signed [SUM_W-1:0]  tot;
  logic signed [SW-1:0]     emf_d, emf_q;

  logic                 s_beat;
  logic                 out_free;
  logic                 busy;
  logic                 load_out;
  dqco_pkg::seq_ctrl_t  ctrl;

  logic [GAIN_W-1:0]        gain;
  logic signed [OPND_W-1:0] mul_opnd;
  logic signed [OPND_W-1:0] opnd_a;
  logic signed [OPND_W-1:0] opnd_b;
  logic signed [OPND_W-1:0] res;
  logic signed [SW-1:0]     res_smp;

  // selected axis views
  logic signed [SW-1:0]    meas_x, volt_x, est_x;
  logic signed [SUM_W-1:0] sum_x;

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_smp(
    input logic signed [OPND_W-1:0] v
  );
    logic signed [SAMPLE_WIDTH-1:0] r;
    if (v > SMP_MAX) begin
      r = SMP_MAX[SAMPLE_WIDTH-1:0];
    end else if (v < SMP_MIN) begin
      r = SMP_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      r = v[SAMPLE_WIDTH-1:0];
    end
    return r;
  endfunction

  assign s_tready = ~busy;
  assign s_beat   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;

  dqco_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (s_beat & ~s_tuser),
    .clear    (s_beat & s_tuser),
    .out_free (out_free),
    .busy     (busy),
    .load_out (load_out),
    .ctrl     (ctrl)
  );

  // gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_d <= dqco_pkg::RST_PROP_GAIN_D;
      ki_d <= dqco_pkg::RST_INTEG_GAIN_D;
      kp_q <= dqco_pkg::RST_PROP_GAIN_Q;
      ki_q <= dqco_pkg::RST_INTEG_GAIN_Q;
      a_d  <= dqco_pkg::RST_POLE_GAIN_D;
      a_q  <= dqco_pkg::RST_POLE_GAIN_Q;
      b_d  <= dqco_pkg::RST_INPUT_GAIN_D;
      b_q  <= dqco_pkg::RST_INPUT_GAIN_Q;
    end else if (cfg_we) begin
      case (cfg_addr)
        dqco_pkg::REG_PROP_GAIN_D:  kp_d <= cfg_wdata;
        dqco_pkg::REG_INTEG_GAIN_D: ki_d <= cfg_wdata;
        dqco_pkg::REG_PROP_GAIN_Q:  kp_q <= cfg_wdata;
        dqco_pkg::REG_INTEG_GAIN_Q: ki_q <= cfg_wdata;
        dqco_pkg::REG_POLE_GAIN_D:  a_d  <= cfg_wdata;
        dqco_pkg::REG_POLE_GAIN_Q:  a_q  <= cfg_wdata;
        dqco_pkg::REG_INPUT_GAIN_D: b_d  <= cfg_wdata;
        dqco_pkg::REG_INPUT_GAIN_Q: b_q  <= cfg_wdata;
        default: begin
          // unlisted index, ignored
        end
      endcase
    end
  end

  // capture the sample beat
  always_ff @(posedge clk) begin
    if (s_beat) begin
      meas_d <= s_tdata[0*SW +: SW];
      meas_q <= s_tdata[1*SW +: SW];
      volt_d <= s_tdata[2*SW +: SW];
      volt_q <= s_tdata[3*SW +: SW];
    end
  end

  // axis selection
  always_comb begin
    meas_x = ctrl.axis ? meas_q : meas_d;
    volt_x = ctrl.axis ? volt_q : volt_d;
    est_x  = ctrl.axis ? est_q  : est_d;
    sum_x  = ctrl.axis ? sum_q  : sum_d;
  end

  // operand selection for the shared unit
  always_comb begin
    case (ctrl.gain_sel)
      dqco_pkg::GSEL_KP: gain = ctrl.axis ? kp_q : kp_d;
      dqco_pkg::GSEL_KI: gain = ctrl.axis ? ki_q : ki_d;
      dqco_pkg::GSEL_A:  gain = ctrl.axis ? a_q  : a_d;
      dqco_pkg::GSEL_B:  gain = ctrl.axis ? b_q  : b_d;
      default:           gain = '0;
    endcase
    case (ctrl.mul_sel)
      dqco_pkg::MSEL_ERR: mul_opnd = err;
      dqco_pkg::MSEL_SUM: mul_opnd = OPND_W'(sum_x);
      dqco_pkg::MSEL_EST: mul_opnd = OPND_W'(est_x);
      dqco_pkg::MSEL_TOT: mul_opnd = OPND_W'(tot);
      default:            mul_opnd = '0;
    endcase
    case (ctrl.a_sel)
      dqco_pkg::ASEL_ZERO: opnd_a = '0;
      dqco_pkg::ASEL_MEAS: opnd_a = OPND_W'(meas_x);
      dqco_pkg::ASEL_SUM:  opnd_a = OPND_W'(sum_x);
      dqco_pkg::ASEL_FB:   opnd_a = OPND_W'(fb);
      default:             opnd_a = '0;
    endcase
    case (ctrl.b_sel)
      dqco_pkg::BSEL_EST:  opnd_b = OPND_W'(est_x);
      dqco_pkg::BSEL_ERR:  opnd_b = err;
      dqco_pkg::BSEL_VOLT: opnd_b = OPND_W'(volt_x);
      dqco_pkg::BSEL_FB:   opnd_b = OPND_W'(fb);
      default:             opnd_b = '0;
    endcase
  end

  dqco_mac #(
    .OPND_W         (OPND_W),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_mac (
    .clk      (clk),
    .ctrl     (ctrl.mac),
    .gain     (gain),
    .mul_opnd (mul_opnd),
    .opnd_a   (opnd_a),
    .opnd_b   (opnd_b),
    .res      (res)
  );

  // sample-range clamp for estimates and back-emf
  assign res_smp = sat_smp(res);

  // working registers; res is already clamped to 32 bits where it is narrowed
  always_ff @(posedge clk) begin
    case (ctrl.dst)
      dqco_pkg::DST_ERR: err <= res;
      dqco_pkg::DST_FB:  fb  <= res[SUM_W-1:0];
      dqco_pkg::DST_TOT: tot <= res[SUM_W-1:0];
      dqco_pkg::DST_EMF: begin
        if (ctrl.axis) begin
          emf_q <= res_smp;
        end else begin
          emf_d <= res_smp;
        end
      end
      default: begin
        // state destinations are handled below
      end
    endcase
    // clear beat: back-emf result is zero
    if (s_beat && s_tuser) begin
      emf_d <= '0;
      emf_q <= '0;
    end
  end

  // observer state: estimates and error sums
  always_ff @(posedge clk) begin
    if (rst) begin
      est_d <= '0;
      est_q <= '0;
      sum_d <= '0;
      sum_q <= '0;
    end else if (s_beat && s_tuser) begin
      est_d <= '0;
      est_q <= '0;
      sum_d <= '0;
      sum_q <= '0;
    end else begin
      if (ctrl.dst == dqco_pkg::DST_SUM) begin
        if (ctrl.axis) begin
          sum_q <= res[SUM_W-1:0];
        end else begin
          sum_d <= res[SUM_W-1:0];
        end
      end
      if (ctrl.dst == dqco_pkg::DST_EST) begin
        if (ctrl.axis) begin
          est_q <= res_smp;
        end else begin
          est_d <= res_smp;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= DATA_W'({emf_q, emf_d, est_q, est_d});
    end
  end

endmodule
